/* design/piecewise_fuzzy_hash_stream_macros.svh */
// ----------------------------------------------------------------------------
// Piecewise fuzzy hash stream - assertion macros
// Concurrent assertion wrappers. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_FUZZY_HASH_STREAM_MACROS_SVH
`define PIECEWISE_FUZZY_HASH_STREAM_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising clock edge outside reset.
`define PFH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition in one cycle is followed by another in the next.
`define PFH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFH_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/pfh_pkg.sv */
// ----------------------------------------------------------------------------
// Piecewise fuzzy hash stream - package
// Shared constants, request and result types.
// ----------------------------------------------------------------------------
package pfh_pkg;

    localparam int WIN_LEN   = 7;          // rolling hash window in bytes
    localparam int Z_SHIFT   = 5;
    localparam int EXP_W     = 5;          // block exponent width
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_MULT  = 32'd16777619;

    // Classified request queue between front and back
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int CR_W      = Q_CNT_W + 1;

    // Result buffer in the back end
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic PART_FINE   = 1'b0;
    localparam logic PART_COARSE = 1'b1;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic       which_part;
        logic [5:0] sextet;
        logic       from_flush;
        logic       run_end;
    } t_out_item;

    // A classified request: byte, end of file mark and the two trigger flags
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
        logic       fine_trig;
        logic       coarse_trig;
    } t_cls;

endpackage

/* design/pfh_front.sv */
// ----------------------------------------------------------------------------
// Piecewise fuzzy hash stream - front end
// Accepts bytes, updates the rolling hash and classifies each byte against
// the fine and coarse block sizes.
// ----------------------------------------------------------------------------
module pfh_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  pfh_pkg::t_in_item           i_in_item,
    input  logic [pfh_pkg::EXP_W-1:0]   i_block_exp,
    input  logic [pfh_pkg::Q_CNT_W-1:0] i_q_count,
    output logic                        o_push,
    output pfh_pkg::t_cls               o_cls
);
    import pfh_pkg::*;

    // Residue mod 3: 256 and 4 are both 1 mod 3, so fold bytes then digits.
    function automatic logic [1:0] f_mod3(input logic [31:0] v);
        logic [9:0] s;
        logic [3:0] t;
        logic [2:0] u;
        logic [2:0] r;
        s = 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[23:16]) + 10'(v[31:24]);
        t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]) + 4'(s[7:6]) + 4'(s[9:8]);
        u = 3'(t[1:0]) + 3'(t[3:2]);
        if (u >= 3'd6) begin
            r = u - 3'd6;
        end else if (u >= 3'd3) begin
            r = u - 3'd3;
        end else begin
            r = u;
        end
        return r[1:0];
    endfunction

    logic [31:0] r_sum_x, r_wsum_y, r_shift_z;
    logic [7:0]  r_win [WIN_LEN];

    logic        r_s1_valid;
    logic [31:0] r_s1_x, r_s1_y, r_s1_z;
    logic [7:0]  r_s1_byte;
    logic        r_s1_last;

    logic        r_s2_valid;
    logic [31:0] r_s2_h;
    logic [7:0]  r_s2_byte;
    logic        r_s2_last;

    logic        accept;
    logic [CR_W-1:0] credit;
    logic [31:0] n_sum_x, n_wsum_y, n_shift_z;
    logic [7:0]  b;
    logic [5:0]  sh_c;
    logic [31:0] mask_f, mask_c;

    // Count queued and in-flight requests so the pipeline never stalls
    assign credit = CR_W'(i_q_count) + CR_W'(r_s1_valid) + CR_W'(r_s2_valid);
    assign o_in_ready = credit < CR_W'(Q_DEPTH);
    assign accept = i_in_valid && o_in_ready;
    assign b = i_in_item.byte_value;

    assign n_sum_x   = r_sum_x + 32'(b) - 32'(r_win[WIN_LEN-1]);
    assign n_wsum_y  = r_wsum_y - r_sum_x + 32'(b) * 32'(WIN_LEN);
    assign n_shift_z = (r_shift_z << Z_SHIFT) ^ 32'(b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_in_item.last_byte)) begin
            r_sum_x   <= '0;
            r_wsum_y  <= '0;
            r_shift_z <= '0;
            for (int i = 0; i < WIN_LEN; i++) begin
                r_win[i] <= '0;
            end
        end else if (accept) begin
            r_sum_x   <= n_sum_x;
            r_wsum_y  <= n_wsum_y;
            r_shift_z <= n_shift_z;
            r_win[0]  <= b;
            for (int i = 1; i < WIN_LEN; i++) begin
                r_win[i] <= r_win[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x    <= n_sum_x;
            r_s1_y    <= n_wsum_y;
            r_s1_z    <= n_shift_z;
            r_s1_byte <= b;
            r_s1_last <= i_in_item.last_byte;
        end
        r_s2_h    <= r_s1_x + r_s1_y + r_s1_z;
        r_s2_byte <= r_s1_byte;
        r_s2_last <= r_s1_last;
    end

    // h mod (3 << k) == (3 << k) - 1 holds when the low k bits are all ones
    // and (h >> k) mod 3 == 2; the coarse test uses k + 1.
    assign sh_c   = 6'(i_block_exp) + 6'd1;
    assign mask_f = 32'((33'd1 << i_block_exp) - 33'd1);
    assign mask_c = 32'((33'd1 << sh_c) - 33'd1);

    always_comb begin
        o_cls.byte_value  = r_s2_byte;
        o_cls.last_byte   = r_s2_last;
        o_cls.fine_trig   = ((r_s2_h & mask_f) == mask_f)
                            && (f_mod3(r_s2_h >> i_block_exp) == 2'd2);
        o_cls.coarse_trig = ((r_s2_h & mask_c) == mask_c)
                            && (f_mod3(r_s2_h >> sh_c) == 2'd2);
    end

    assign o_push = r_s2_valid;

endmodule

/* design/pfh_queue.sv */
// ----------------------------------------------------------------------------
// Piecewise fuzzy hash stream - request queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`include "piecewise_fuzzy_hash_stream_macros.svh"
module pfh_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  pfh_pkg::t_cls               i_data,
    input  logic                        i_pop,
    output pfh_pkg::t_cls               o_data,
    output logic [pfh_pkg::Q_CNT_W-1:0] o_count
);
    import pfh_pkg::*;

    t_cls               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    `PFH_ASSERT(a_no_overflow, i_clk, i_rst_n, !i_push || (r_count < Q_CNT_W'(Q_DEPTH)), "queue overflow")
    `PFH_ASSERT(a_no_underflow, i_clk, i_rst_n, !i_pop || (r_count != '0), "queue underflow")

endmodule

/* design/pfh_back.sv */
// ----------------------------------------------------------------------------
// Piecewise fuzzy hash stream - back end
// Runs the two FNV accumulators, forms fine and coarse results and buffers
// them for the output channel.
// ----------------------------------------------------------------------------
`include "piecewise_fuzzy_hash_stream_macros.svh"
module pfh_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pfh_pkg::t_cls               i_cls,
    input  logic [pfh_pkg::Q_CNT_W-1:0] i_q_count,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output pfh_pkg::t_out_item          o_out_item
);
    import pfh_pkg::*;

    logic [31:0]          r_fnv_fine, r_fnv_coarse;
    t_out_item            r_res [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr, r_rd;
    logic [RES_CNT_W-1:0] r_res_cnt;

    logic [31:0] fnv_f, fnv_c;
    logic        has_f, has_c, both, out_take;
    logic [1:0]  n_push;
    t_out_item   res0, res1;

    // Take a request only when the buffer has room for two results
    assign o_pop = (i_q_count != '0) && (r_res_cnt <= RES_CNT_W'(RES_DEPTH - 2));

    assign fnv_f = (r_fnv_fine * FNV_MULT) ^ 32'(i_cls.byte_value);
    assign fnv_c = (r_fnv_coarse * FNV_MULT) ^ 32'(i_cls.byte_value);

    // A part gives a result on its trigger, or on end of file when not just
    // triggered (the accumulator has taken this byte at least).
    assign has_f = i_cls.fine_trig || i_cls.last_byte;
    assign has_c = i_cls.coarse_trig || i_cls.last_byte;
    assign both  = has_f && has_c;
    assign n_push = o_pop ? (2'(has_f) + 2'(has_c)) : 2'd0;

    always_comb begin
        res0.which_part = has_f ? PART_FINE : PART_COARSE;
        res0.sextet     = has_f ? fnv_f[5:0] : fnv_c[5:0];
        res0.from_flush = has_f ? !i_cls.fine_trig : !i_cls.coarse_trig;
        res0.run_end    = !both;
        res1.which_part = PART_COARSE;
        res1.sextet     = fnv_c[5:0];
        res1.from_flush = !i_cls.coarse_trig;
        res1.run_end    = 1'b1;
    end

    assign out_take = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fnv_fine   <= FNV_BASIS;
            r_fnv_coarse <= FNV_BASIS;
            r_wr         <= '0;
            r_rd         <= '0;
            r_res_cnt    <= '0;
        end else begin
            if (o_pop) begin
                r_fnv_fine   <= has_f ? FNV_BASIS : fnv_f;
                r_fnv_coarse <= has_c ? FNV_BASIS : fnv_c;
            end
            r_wr      <= r_wr + RES_PTR_W'(n_push);
            if (out_take) begin
                r_rd <= r_rd + 1'b1;
            end
            r_res_cnt <= r_res_cnt + RES_CNT_W'(n_push) - RES_CNT_W'(out_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_res[r_wr] <= res0;
        end
        if (n_push == 2'd2) begin
            r_res[r_wr + 1'b1] <= res1;
        end
    end

    assign o_out_valid = r_res_cnt != '0;
    assign o_out_item  = r_res[r_rd];

    `PFH_ASSERT(a_res_bound, i_clk, i_rst_n, r_res_cnt <= RES_CNT_W'(RES_DEPTH), "result buffer overrun")
    `PFH_ASSERT_NEXT(a_eof_clear, i_clk, i_rst_n, o_pop && i_cls.last_byte, (r_fnv_fine == FNV_BASIS) && (r_fnv_coarse == FNV_BASIS), "accumulators not cleared at end of file")

endmodule

/* design/piecewise_fuzzy_hash_stream.sv */
// ----------------------------------------------------------------------------
// Piecewise fuzzy hash stream - top level
// Context-triggered piecewise hashing of a byte stream into fine and coarse
// base64 sextets.
// ----------------------------------------------------------------------------
// Path: front stages s1 and s2, then the request queue, then the result buffer.
// Throughput: one byte per cycle while o_in_ready is high; each result holds the
//   output for one cycle, so a byte with two results can back up the queue and drop ready.
// The four-entry request queue and four-entry result buffer set the stall slack.
// Reset: synchronous, active low; clears sums, window, accumulators, queues and
//   the block exponent (to zero) directly, with no clearing pass.
module piecewise_fuzzy_hash_stream (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // byte requests
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  pfh_pkg::t_in_item         i_in_item,
    // result requests
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output pfh_pkg::t_out_item        o_out_item,
    // block exponent register
    input  logic                      i_cfg_we,
    input  logic [pfh_pkg::EXP_W-1:0] i_cfg_data
);
    import pfh_pkg::*;

    logic [EXP_W-1:0]   r_block_exp;
    logic               push, pop;
    t_cls               push_cls, head_cls;
    logic [Q_CNT_W-1:0] q_count;

    // Hold the block exponent; the fine block size is 3 << r_block_exp. The
    // end-of-file clear leaves it alone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_exp <= '0;
        end else if (i_cfg_we) begin
            r_block_exp <= i_cfg_data;
        end
    end

    // Front: accept, roll the hash, classify against both block sizes.
    // Ready follows the queue credit, so the front pipeline never stalls.
    pfh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_block_exp (r_block_exp),
        .i_q_count   (q_count),
        .o_push      (push),
        .o_cls       (push_cls)
    );

    // Decouple the front from the back so either side may stall
    pfh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cls),
        .i_pop   (pop),
        .o_data  (head_cls),
        .o_count (q_count)
    );

    // Back: advance the FNV accumulators, emit triggered and flushed sextets,
    // fine part before coarse part.
    pfh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls       (head_cls),
        .i_q_count   (q_count),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
